FILE: src/sps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the shortest path solver
// no dependencies

package sps_pkg;

  localparam int VERT_W   = 6;
  localparam int DIST_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 7;
  localparam int EDGE_W   = 2 * VERT_W + WEIGHT_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SOLVE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEARCH,
    ST_PICK,
    ST_EDGE,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // running minimum handed down the cell row
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] cost;
    logic [VERT_W-1:0] idx;
  } cand_t;

  // relaxation request travelling down the cell row
  typedef struct packed {
    logic              valid;
    logic [VERT_W-1:0] target;
    logic [DIST_W-1:0] cost;
  } relax_t;

  // per-cell result, shifted toward cell zero during readout
  typedef struct packed {
    logic [DIST_W-1:0] cost;
    logic              settled;
  } slot_t;

  typedef struct packed {
    logic              clear;
    logic              seed;
    logic              settle;
    logic              shift;
    logic [VERT_W-1:0] sel;
  } cell_ctl_t;

endpackage

FILE: src/sps_in_if.sv
`timescale 1ns / 1ps
// command channel: edge adds and solve requests
// depends on sps_pkg

interface sps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [sps_pkg::VERT_W-1:0]   edge_end_a;
  logic [sps_pkg::VERT_W-1:0]   edge_end_b;
  logic [sps_pkg::WEIGHT_W-1:0] edge_weight;
  logic [sps_pkg::VERT_W-1:0]   start_node;

  modport source (output valid, opcode, edge_end_a, edge_end_b, edge_weight, start_node,
                  input ready);
  modport sink (input valid, opcode, edge_end_a, edge_end_b, edge_weight, start_node,
                output ready);
endinterface

FILE: src/sps_out_if.sv
`timescale 1ns / 1ps
// result channel: one transaction per vertex
// depends on sps_pkg

interface sps_out_if;
  logic                       valid;
  logic                       ready;
  logic [sps_pkg::VERT_W-1:0] vertex_index;
  logic [sps_pkg::DIST_W-1:0] distance;
  logic                       reachable;
  logic                       last_result;

  modport source (output valid, vertex_index, distance, reachable, last_result,
                  input ready);
  modport sink (input valid, vertex_index, distance, reachable, last_result,
                output ready);
endinterface

FILE: src/shortest_path_solver.sv
`timescale 1ns / 1ps
// edge add: written to the edge store on acceptance. solve: a clear and a min search,
// then per settled vertex a pick, an edge store scan, a relax drain down the cell row and
// a min search down the row; then n results at up to one per cycle, stalled by res.ready.
// one item in flight at a time; the cell row length sets the per-vertex cost.
// synchronous reset clears control, edge count and cells; the edge ram needs no clearing.
// depends on sps_pkg, sps_in_if, sps_out_if, sps_ram, sps_cell

module shortest_path_solver #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [sps_pkg::CFG_W-1:0] cfg_data,
  sps_in_if.sink                    cmd,
  sps_out_if.source                 res
);

  localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW     = $clog2(MAX_EDGES + 1);
  localparam int WAIT_W = $clog2(MAX_VERTICES + 4);

  sps_pkg::state_t state, state_next;

  logic [sps_pkg::CFG_W-1:0]  vertex_count;
  logic [sps_pkg::CFG_W-1:0]  n_eff;
  logic [CW-1:0]              edge_count;
  logic [CW-1:0]              edge_ptr;
  logic [WAIT_W-1:0]          wait_cnt;
  logic [sps_pkg::CFG_W-1:0]  out_cnt;
  logic [sps_pkg::VERT_W-1:0] src;
  logic [sps_pkg::VERT_W-1:0] best_idx;
  logic [sps_pkg::DIST_W-1:0] best_dist;
  logic                       rd_valid;
  logic                       rd_en;
  logic                       out_load;
  logic [sps_pkg::EDGE_W-1:0] rdata;
  sps_pkg::relax_t            msg;
  sps_pkg::cell_ctl_t         ctl;

  sps_pkg::cand_t  cand  [MAX_VERTICES];
  sps_pkg::relax_t relax [MAX_VERTICES];
  sps_pkg::slot_t  slot  [MAX_VERTICES];

  logic add_accept;
  logic solve_accept;
  assign add_accept   = cmd.valid && cmd.ready && (cmd.opcode == sps_pkg::OP_ADD_EDGE);
  assign solve_accept = cmd.valid && cmd.ready && (cmd.opcode == sps_pkg::OP_SOLVE);
  assign cmd.ready    = (state == sps_pkg::ST_IDLE);

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = sps_pkg::CFG_W'(1);
    end else if (vertex_count > sps_pkg::CFG_W'(MAX_VERTICES)) begin
      n_eff = sps_pkg::CFG_W'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= sps_pkg::CFG_W'(64);
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  sps_ram #(.WIDTH(sps_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (add_accept && (edge_count < CW'(MAX_EDGES))),
    .waddr (edge_count[AW-1:0]),
    .wdata ({cmd.edge_end_a, cmd.edge_end_b, cmd.edge_weight}),
    .raddr (edge_ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.sel    = src;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      sps_pkg::ST_IDLE: begin
        if (solve_accept) begin
          state_next = sps_pkg::ST_CLEAR;
        end
      end
      sps_pkg::ST_CLEAR: begin
        ctl.clear  = 1'b1;
        ctl.seed   = ({1'b0, src} < n_eff);
        state_next = sps_pkg::ST_SEARCH;
      end
      sps_pkg::ST_SEARCH: begin
        if (wait_cnt == WAIT_W'(MAX_VERTICES)) begin
          state_next = sps_pkg::ST_PICK;
        end
      end
      sps_pkg::ST_PICK: begin
        ctl.sel = cand[MAX_VERTICES-1].idx;
        if (cand[MAX_VERTICES-1].valid) begin
          ctl.settle = 1'b1;
          state_next = sps_pkg::ST_EDGE;
        end else begin
          state_next = sps_pkg::ST_OUT;
        end
      end
      sps_pkg::ST_EDGE: begin
        rd_en = (edge_ptr < edge_count);
        if (edge_ptr == edge_count) begin
          state_next = sps_pkg::ST_DRAIN;
        end
      end
      sps_pkg::ST_DRAIN: begin
        if (wait_cnt == WAIT_W'(MAX_VERTICES + 2)) begin
          state_next = sps_pkg::ST_SEARCH;
        end
      end
      sps_pkg::ST_OUT: begin
        out_load  = (out_cnt < n_eff) && (!res.valid || res.ready);
        ctl.shift = out_load;
        if (out_cnt == n_eff) begin
          state_next = sps_pkg::ST_IDLE;
        end
      end
      default: state_next = sps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic [sps_pkg::DIST_W:0] sum;
  assign sum = {1'b0, best_dist} + (sps_pkg::DIST_W + 1)'(rdata[15:0]);

  always_ff @(posedge clk) begin
    // saturating path length toward the far endpoint
    msg.target <= (rdata[27:22] == best_idx) ? rdata[21:16] : rdata[27:22];
    msg.cost   <= sum[sps_pkg::DIST_W] ? sps_pkg::DIST_MAX : sum[sps_pkg::DIST_W-1:0];
    if (rst) begin
      edge_count <= '0;
      edge_ptr   <= '0;
      wait_cnt   <= '0;
      out_cnt    <= '0;
      rd_valid   <= 1'b0;
      msg.valid  <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      wait_cnt <= (state_next != state) ? '0 : wait_cnt + WAIT_W'(1);
      rd_valid <= rd_en;
      if (add_accept && (edge_count < CW'(MAX_EDGES))) begin
        edge_count <= edge_count + CW'(1);
      end
      if (state == sps_pkg::ST_PICK) begin
        edge_ptr <= '0;
        if (!cand[MAX_VERTICES-1].valid) begin
          edge_count <= '0;
          out_cnt    <= '0;
        end
      end else if (rd_en) begin
        edge_ptr <= edge_ptr + CW'(1);
      end
      if (out_load) begin
        out_cnt <= out_cnt + sps_pkg::CFG_W'(1);
      end
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      msg.valid <= rd_valid &&
                   ({1'b0, rdata[27:22]} < n_eff) && ({1'b0, rdata[21:16]} < n_eff) &&
                   ((rdata[27:22] == best_idx) || (rdata[21:16] == best_idx));
    end
  end

  always_ff @(posedge clk) begin
    if (solve_accept) begin
      src <= cmd.start_node;
    end
    if (state == sps_pkg::ST_PICK) begin
      best_idx  <= cand[MAX_VERTICES-1].idx;
      best_dist <= cand[MAX_VERTICES-1].cost;
    end
    if (out_load) begin
      res.vertex_index <= out_cnt[sps_pkg::VERT_W-1:0];
      res.distance     <= slot[0].cost;
      res.reachable    <= slot[0].settled;
      res.last_result  <= (out_cnt + sps_pkg::CFG_W'(1) == n_eff);
    end
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    sps_pkg::cand_t  c_in;
    sps_pkg::relax_t r_in;
    sps_pkg::slot_t  s_in;
    if (k == 0) begin : g_head
      assign c_in = '0;
      assign r_in = msg;
    end else begin : g_body
      assign c_in = cand[k-1];
      assign r_in = relax[k-1];
    end
    if (k == MAX_VERTICES - 1) begin : g_tail
      assign s_in = '0;
    end else begin : g_link
      assign s_in = slot[k+1];
    end
    sps_cell #(.IDX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .cand_in   (c_in),
      .cand_out  (cand[k]),
      .relax_in  (r_in),
      .relax_out (relax[k]),
      .slot_in   (s_in),
      .slot_out  (slot[k])
    );
  end

  a_edge_count_bound: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sps_pkg::ST_EDGE) |-> (edge_ptr <= edge_count))
    else $error("edge pointer ran past stored edges");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == sps_pkg::ST_PICK) && cand[MAX_VERTICES-1].valid) |->
      ({1'b0, cand[MAX_VERTICES-1].idx} < n_eff))
    else $error("picked vertex outside graph");

  a_result_only_in_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == sps_pkg::ST_OUT))
    else $error("result raised outside readout");

endmodule

FILE: src/sps_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module sps_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sps_cell.sv
`timescale 1ns / 1ps
// one vertex cell: distance, reached and settled state plus neighbor links
// depends on sps_pkg

module sps_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  sps_pkg::cell_ctl_t ctl,
  input  sps_pkg::cand_t     cand_in,
  output sps_pkg::cand_t     cand_out,
  input  sps_pkg::relax_t    relax_in,
  output sps_pkg::relax_t    relax_out,
  input  sps_pkg::slot_t     slot_in,
  output sps_pkg::slot_t     slot_out
);

  logic [sps_pkg::DIST_W-1:0] cost;
  logic                       reached;
  logic                       settled;
  logic                       me_sel;
  logic                       relax_hit;
  logic                       eligible;

  assign me_sel    = (ctl.sel == sps_pkg::VERT_W'(IDX));
  assign relax_hit = relax_in.valid && (relax_in.target == sps_pkg::VERT_W'(IDX)) &&
                     !settled && (!reached || (relax_in.cost < cost));
  assign eligible  = reached && !settled;
  assign slot_out  = '{cost: cost, settled: settled};

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= 1'b0;
      settled <= 1'b0;
      cost    <= sps_pkg::DIST_MAX;
    end else if (ctl.clear) begin
      reached <= ctl.seed && me_sel;
      settled <= 1'b0;
      cost    <= (ctl.seed && me_sel) ? '0 : sps_pkg::DIST_MAX;
    end else if (ctl.shift) begin
      cost    <= slot_in.cost;
      settled <= slot_in.settled;
    end else begin
      if (ctl.settle && me_sel) begin
        settled <= 1'b1;
      end
      if (relax_hit) begin
        cost    <= relax_in.cost;
        reached <= 1'b1;
      end
    end
  end

  // strict compare keeps the lower index on ties
  always_ff @(posedge clk) begin
    relax_out.target <= relax_in.target;
    relax_out.cost   <= relax_in.cost;
    if (eligible && (!cand_in.valid || (cost < cand_in.cost))) begin
      cand_out.cost <= cost;
      cand_out.idx  <= sps_pkg::VERT_W'(IDX);
    end else begin
      cand_out.cost <= cand_in.cost;
      cand_out.idx  <= cand_in.idx;
    end
    if (rst) begin
      cand_out.valid  <= 1'b0;
      relax_out.valid <= 1'b0;
    end else begin
      relax_out.valid <= relax_in.valid;
      if (eligible && (!cand_in.valid || (cost < cand_in.cost))) begin
        cand_out.valid <= 1'b1;
      end else begin
        cand_out.valid <= cand_in.valid;
      end
    end
  end

endmodule

FILE: test/sps_test_pkg.sv
`timescale 1ns / 1ps
// expected-result and command types for the shortest path solver test
// depends on sps_pkg

package sps_test_pkg;
  import sps_pkg::*;

  typedef struct packed {
    logic [VERT_W-1:0] vertex_index;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last_result;
  } vertex_result_t;

  typedef struct packed {
    logic                opcode;
    logic [VERT_W-1:0]   edge_end_a;
    logic [VERT_W-1:0]   edge_end_b;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [VERT_W-1:0]   start_node;
  } command_t;
endpackage

FILE: test/shortest_path_solver_test.sv
`timescale 1ns / 1ps
// stimulus and checking for shortest_path_solver: directed and random graphs, solves
// checked per vertex against an in-bench path search; depends on sps_pkg, sps_test_pkg,
// sps_in_if, sps_out_if, shortest_path_solver

module shortest_path_solver_test;
  import sps_pkg::*;
  import sps_test_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  sps_in_if cmd();
  sps_out_if res();

  shortest_path_solver u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .cmd(cmd.sink), .res(res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [VERT_W-1:0]   graph_a [NE];
  logic [VERT_W-1:0]   graph_b [NE];
  logic [WEIGHT_W-1:0] graph_w [NE];
  int unsigned graph_edges = 0;
  int unsigned node_limit = NV;

  vertex_result_t pending_results[$];
  int errors = 0;
  int unsigned cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  initial begin
    cmd.valid = 1'b0;
    cmd.opcode = OP_ADD_EDGE;
    cmd.edge_end_a = '0;
    cmd.edge_end_b = '0;
    cmd.edge_weight = '0;
    cmd.start_node = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] x, logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  task automatic predict_paths(input logic [VERT_W-1:0] src);
    logic [DIST_W-1:0] cost [NV];
    bit settled [NV];
    bit seen [NV];
    int unsigned n, best, e, a, b, from, to;
    logic [DIST_W-1:0] nd;
    vertex_result_t r;
    n = node_limit;
    for (int i = 0; i < NV; i++) begin
      cost[i] = DIST_MAX;
      settled[i] = 0;
      seen[i] = 0;
    end
    if (src < n) begin
      cost[src] = '0;
      seen[src] = 1;
      forever begin
        best = n;
        for (int i = 0; i < n; i++)
          if (seen[i] && !settled[i] && (best == n || cost[i] < cost[best])) best = i;
        if (best == n) break;
        settled[best] = 1;
        for (e = 0; e < graph_edges; e++) begin
          a = graph_a[e];
          b = graph_b[e];
          if (a >= n || b >= n) continue;
          for (int side = 0; side < 2; side++) begin
            from = side ? b : a;
            to = side ? a : b;
            if (from != best) continue;
            nd = sat_sum(cost[from], DIST_W'(graph_w[e]));
            if (!settled[to] && (!seen[to] || nd < cost[to])) begin
              cost[to] = nd;
              seen[to] = 1;
            end
          end
        end
      end
    end
    graph_edges = 0;
    for (int i = 0; i < n; i++) begin
      r.vertex_index = i[VERT_W-1:0];
      r.distance = cost[i];
      r.reachable = settled[i];
      r.last_result = (i + 1 == n);
      pending_results = {pending_results, r};
    end
  endtask

  // valid stays up between back-to-back commands; idle gaps and drain lower it
  task automatic send_command(input command_t c);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.opcode <= c.opcode;
    cmd.edge_end_a <= c.edge_end_a;
    cmd.edge_end_b <= c.edge_end_b;
    cmd.edge_weight <= c.edge_weight;
    cmd.start_node <= c.start_node;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (c.opcode == OP_ADD_EDGE) begin
      if (graph_edges < NE) begin
        graph_a[graph_edges] = c.edge_end_a;
        graph_b[graph_edges] = c.edge_end_b;
        graph_w[graph_edges] = c.edge_weight;
        graph_edges++;
      end
    end else begin
      predict_paths(c.start_node);
    end
    @(negedge clk);
  endtask

  task automatic add_edge(input int a, input int b, input int w);
    command_t c;
    c = '0;
    c.opcode = OP_ADD_EDGE;
    c.edge_end_a = VERT_W'(a);
    c.edge_end_b = VERT_W'(b);
    c.edge_weight = WEIGHT_W'(w);
    send_command(c);
  endtask

  task automatic solve_from(input int s);
    command_t c;
    c.opcode = OP_SOLVE;
    c.edge_end_a = VERT_W'($urandom);
    c.edge_end_b = VERT_W'($urandom);
    c.edge_weight = WEIGHT_W'($urandom);
    c.start_node = VERT_W'(s);
    send_command(c);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // only while idle
  task automatic set_vertex_count(input int v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= CFG_W'(v);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (v == 0) node_limit = 1;
    else if (v > NV) node_limit = NV;
    else node_limit = v;
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst) res.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      res.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else res.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    vertex_result_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction vertex %0d", res.vertex_index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res.vertex_index !== exp_r.vertex_index) begin
          $error("vertex_index expected %0d got %0d", exp_r.vertex_index, res.vertex_index);
          errors++;
        end
        if (res.distance !== exp_r.distance) begin
          $error("distance expected %0h got %0h", exp_r.distance, res.distance);
          errors++;
        end
        if (res.reachable !== exp_r.reachable) begin
          $error("reachable expected %0b got %0b", exp_r.reachable, res.reachable);
          errors++;
        end
        if (res.last_result !== exp_r.last_result) begin
          $error("last_result expected %0b got %0b", exp_r.last_result, res.last_result);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    set_vertex_count(8);
    add_edge(0, 1, 4);
    add_edge(1, 2, 65535);
    add_edge(0, 2, 0);
    add_edge(3, 3, 7);
    add_edge(2, 5, 10);
    add_edge(5, 1, 1);
    add_edge(9, 4, 1);
    solve_from(0);
    add_edge(0, 1, 3);
    solve_from(9);
    solve_from(7);
    set_vertex_count(1);
    add_edge(0, 0, 5);
    solve_from(0);
    set_vertex_count(0);
    solve_from(0);
    set_vertex_count(127);
    add_edge(63, 0, 65535);
    add_edge(62, 63, 65535);
    add_edge(42, 21, 21845);
    solve_from(63);
    set_vertex_count(64);
    solve_from(63);
  endtask

  // heavy weights across the full vertex range
  task automatic test_dense_graph();
    set_vertex_count(64);
    for (int i = 0; i < 12; i++)
      add_edge($urandom_range(63, 0), $urandom_range(63, 0), $urandom_range(65535, 0));
    solve_from($urandom_range(63, 0));
  endtask

  task automatic random_graph(input int count, input int nv);
    for (int i = 0; i < count; i++)
      add_edge($urandom_range(nv - 1, 0), $urandom_range(nv - 1, 0),
               ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(20, 0));
    solve_from(($urandom_range(9, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(nv - 1, 0));
  endtask

  task automatic test_random(input int sp, input int rp);
    int nv;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int g = 0; g < 3; g++) begin
      nv = ($urandom_range(4, 0) == 0) ? 64 : $urandom_range(12, 2);
      set_vertex_count(nv);
      random_graph($urandom_range(10, 2), nv);
    end
  endtask

  // long receiver hold while solves keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_vertex_count(16);
    hold_cycles = 3000;
    random_graph(6, 16);
    random_graph(6, 16);
    random_graph(3, 16);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_dense_graph();
    test_random(10, 45);
    test_random(45, 10);
    test_random(0, 0);
    test_backpressure();
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: files.f
src/sps_pkg.sv
src/sps_in_if.sv
src/sps_out_if.sv
src/sps_ram.sv
src/sps_cell.sv
src/shortest_path_solver.sv
test/sps_test_pkg.sv
test/shortest_path_solver_test.sv
